FILE: hdl/le_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// le_pkg: shared types and constants of the serial line editor
// Byte codes, widths, sequencer states and the structs between modules.
// ----------------------------------------------------------------------------
package le_pkg;

  localparam int LINE_MAX = 64;
  localparam int IDX_W    = $clog2(LINE_MAX);
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int CNT_W    = 16;
  localparam int PROD_W   = CNT_W + 4;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_MAX - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_EMIT_LF,
    S_STATUS
  } state_e;

  // one result beat
  typedef struct packed {
    logic             is_line_byte;
    logic [7:0]       line_byte;
    logic [IDX_W-1:0] cursor_pos;
    logic [LEN_W-1:0] line_length;
    logic             last;
    logic             overflow;
  } res_t;

  // line store access
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: hdl/le_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// le_line_mem: line store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module le_line_mem
  import le_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [LINE_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/le_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// le_ctrl: edit sequencer
// Decodes a byte, walks the line store one entry per read/write pair for
// insert/delete, per read and push for emission, and pushes result beats.
// ----------------------------------------------------------------------------
module le_ctrl
  import le_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       slot_free_i,
  output logic       push_o,
  output res_t       res_o,
  output mem_req_t   mem_req_o,
  input  logic [7:0] mem_rdata_i
);

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       prev_q, prev_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [7:0]       byte_q, byte_d;
  logic             ovf_q, ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_NORMAL;
      len_q   <= '0;
      cur_q   <= '0;
      cnt_q   <= '0;
      prev_q  <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    logic [7:0]        cb;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  mv;
    logic [LEN_W-1:0]  room;

    state_d   = state_q;
    phase_d   = phase_q;
    len_d     = len_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    prev_d    = prev_q;
    idx_d     = idx_q;
    byte_d    = byte_q;
    ovf_d     = ovf_q;
    push_o    = 1'b0;
    res_o     = '0;
    mem_req_o = '0;

    cb   = (rx_byte_i == CH_CR) ? CH_LF : rx_byte_i;
    prod = (PROD_W'(cnt_q) << 3) + (PROD_W'(cnt_q) << 1) + PROD_W'(cb[3:0]);
    mv   = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
    room = len_q - LEN_W'(cur_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !(prev_q == CH_CR && rx_byte_i == CH_LF)) begin
          prev_d = rx_byte_i;
          if (rx_byte_i == CH_BS || rx_byte_i == CH_DEL) begin
            if (cur_q != '0 && len_q != '0) begin
              idx_d   = LEN_W'(cur_q);
              state_d = S_DEL_RD;
            end
          end else if (rx_byte_i == CH_ESC) begin
            phase_d = PH_ESC;
          end else begin
            case (phase_q)
              PH_ESC: begin
                if (cb == CH_LBRACK) begin
                  phase_d = PH_CSI;
                  cnt_d   = '0;
                end else begin
                  phase_d = PH_NORMAL;
                end
              end
              PH_CSI: begin
                if (cb >= CH_ZERO && cb <= CH_NINE) begin
                  cnt_d = (prod[PROD_W-1:CNT_W] != '0) ? CNT_MAX : prod[CNT_W-1:0];
                end else if (cb == CH_SEMI) begin
                  cnt_d = '0;
                end else begin
                  phase_d = PH_NORMAL;
                  ovf_d   = 1'b0;
                  if (cb == CH_RIGHT) begin
                    if (CNT_W'(room) < mv) begin
                      cur_d = len_q[IDX_W-1:0];
                    end else begin
                      cur_d = cur_q + mv[IDX_W-1:0];
                    end
                    state_d = S_STATUS;
                  end else if (cb == CH_LEFT) begin
                    if (mv < CNT_W'(cur_q)) begin
                      cur_d = cur_q - mv[IDX_W-1:0];
                    end else begin
                      cur_d = '0;
                    end
                    state_d = S_STATUS;
                  end else if (cb == CH_UP || cb == CH_DOWN) begin
                    state_d = S_STATUS;
                  end
                end
              end
              default: begin
                phase_d = PH_NORMAL;
                if (cb == CH_LF) begin
                  idx_d   = '0;
                  state_d = S_EMIT_RD;
                end else if (len_q >= LEN_FULL) begin
                  ovf_d   = 1'b1;
                  state_d = S_STATUS;
                end else begin
                  byte_d  = cb;
                  idx_d   = len_q;
                  ovf_d   = 1'b0;
                  state_d = S_INS_RD;
                end
              end
            endcase
          end
        end
      end

      // close the gap: entry idx moves down to idx-1
      S_DEL_RD: begin
        if (idx_q < len_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[IDX_W-1:0];
          state_d         = S_DEL_WR;
        end else begin
          len_d   = len_q - LEN_W'(1);
          cur_d   = cur_q - IDX_W'(1);
          ovf_d   = 1'b0;
          state_d = S_STATUS;
        end
      end
      S_DEL_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q[IDX_W-1:0] - IDX_W'(1);
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_q + LEN_W'(1);
        state_d         = S_DEL_RD;
      end

      // open a gap: entry idx-1 moves up to idx, from the top down
      S_INS_RD: begin
        if (idx_q > LEN_W'(cur_q)) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[IDX_W-1:0] - IDX_W'(1);
          state_d         = S_INS_WR;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cur_q;
          mem_req_o.wdata = byte_q;
          len_d           = len_q + LEN_W'(1);
          cur_d           = cur_q + IDX_W'(1);
          state_d         = S_STATUS;
        end
      end
      S_INS_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q[IDX_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_q - LEN_W'(1);
        state_d         = S_INS_RD;
      end

      S_EMIT_RD: begin
        if (idx_q < len_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[IDX_W-1:0];
          state_d         = S_EMIT_OUT;
        end else begin
          state_d = S_EMIT_LF;
        end
      end
      S_EMIT_OUT: begin
        if (slot_free_i) begin
          push_o             = 1'b1;
          res_o.is_line_byte = 1'b1;
          res_o.line_byte    = mem_rdata_i;
          idx_d              = idx_q + LEN_W'(1);
          state_d            = S_EMIT_RD;
        end
      end
      S_EMIT_LF: begin
        if (slot_free_i) begin
          push_o             = 1'b1;
          res_o.is_line_byte = 1'b1;
          res_o.line_byte    = CH_LF;
          res_o.last         = 1'b1;
          len_d              = '0;
          cur_d              = '0;
          state_d            = S_IDLE;
        end
      end

      S_STATUS: begin
        if (slot_free_i) begin
          push_o            = 1'b1;
          res_o.cursor_pos  = cur_q;
          res_o.line_length = len_q;
          res_o.last        = 1'b1;
          res_o.overflow    = ovf_q;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/uart_line_editor_csi.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_editor_csi: serial line editor with ANSI cursor keys
// Edits one line from received bytes; emits status beats and finished lines.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o| rx_byte_i
//   out     | out_valid_o/out_ready_i| is_line_byte_o, line_byte_o,
//           |                        | cursor_pos_o, line_length_o, last_o,
//           |                        | overflow_o
//
// An insert or delete shifts the entries past the cursor one read/write
//   pair at a time through the single read port of the line store. A line
//   end gives one beat per held byte and one for the closing LF.
// Reset clears the line to empty and the parser to its normal phase at once.
// in_ready_o is high only while the sequencer is idle. A result beat sits in
//   the output register; a stalled out_ready_i holds the sequencer.
//
module uart_line_editor_csi
  import le_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             is_line_byte_o,
  output logic [7:0]       line_byte_o,
  output logic [IDX_W-1:0] cursor_pos_o,
  output logic [LEN_W-1:0] line_length_o,
  output logic             last_o,
  output logic             overflow_o
);

  logic     slot_free;
  logic     push;
  res_t     res;
  res_t     out_q;
  logic     out_valid_q;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;

  // the output register can take a new beat if empty or draining now
  assign slot_free = !out_valid_q || out_ready_i;

  le_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .slot_free_i (slot_free),
    .push_o      (push),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  le_line_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_line_byte_o = out_q.is_line_byte;
  assign line_byte_o    = out_q.line_byte;
  assign cursor_pos_o   = out_q.cursor_pos;
  assign line_length_o  = out_q.line_length;
  assign last_o         = out_q.last;
  assign overflow_o     = out_q.overflow;

endmodule

FILE: hdl/le_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// le_checker: port-level checks for the line editor
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module le_checker
  import le_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             is_line_byte_o,
  input logic [7:0]       line_byte_o,
  input logic [IDX_W-1:0] cursor_pos_o,
  input logic [LEN_W-1:0] line_length_o,
  input logic             last_o,
  input logic             overflow_o
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(line_byte_o) && $stable(is_line_byte_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // status beats are single and describe a legal line
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_line_byte_o |->
      last_o && (line_length_o <= LEN_FULL) && (LEN_W'(cursor_pos_o) <= line_length_o))
    else $error("bad status beat");

  // line beats carry no status
  a_line_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_line_byte_o |->
      (cursor_pos_o == '0) && (line_length_o == '0) && !overflow_o)
    else $error("line beat carries status fields");

  // a line always closes with LF
  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_line_byte_o && last_o |-> line_byte_o == CH_LF)
    else $error("line did not end with LF");

endmodule

bind uart_line_editor_csi le_checker u_le_checker (.*);
